>>> sv/ipab_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the integer_parse_any_base block.
// No dependencies; imported by every module of the block.
package ipab_pkg;

  localparam int MAX_BASE  = 16;                 // symbols in the base table
  localparam int SYM_W     = 8;
  localparam int IDX_W     = $clog2(MAX_BASE);   // digit index width
  localparam int LEN_W     = $clog2(MAX_BASE) + 1;
  localparam int SYMS_W    = MAX_BASE * SYM_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int VAL_W     = 32;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN     = 2'd2;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } digit_t;

  function automatic logic is_space(input logic [SYM_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

>>> sv/ipab_base_check.sv
`timescale 1ns / 1ps
// Base table validity check: length range, forbidden symbols, duplicates.
// Depends on ipab_pkg.
module ipab_base_check
  import ipab_pkg::*;
(
  input  logic [SYMS_W-1:0] syms,
  input  logic [LEN_W-1:0]  base_len,
  output logic              base_ok
);

  logic [MAX_BASE-1:0] sym_bad;

  always_comb begin
    for (int k = 0; k < MAX_BASE; k++) begin
      sym_bad[k] = 1'b0;
      if (LEN_W'(k) < base_len) begin
        if (syms[k*SYM_W +: SYM_W] == CH_NUL || syms[k*SYM_W +: SYM_W] == CH_PLUS ||
            syms[k*SYM_W +: SYM_W] == CH_MINUS || is_space(syms[k*SYM_W +: SYM_W])) begin
          sym_bad[k] = 1'b1;
        end
        // repeat of any earlier symbol
        for (int j = 0; j < k; j++) begin
          if (syms[j*SYM_W +: SYM_W] == syms[k*SYM_W +: SYM_W]) begin
            sym_bad[k] = 1'b1;
          end
        end
      end
    end
  end

  assign base_ok = (base_len >= LEN_W'(2)) && (base_len <= LEN_W'(MAX_BASE)) && !(|sym_bad);

endmodule

>>> sv/ipab_digit_match.sv
`timescale 1ns / 1ps
// Parallel lookup of one character in the base symbol table.
// Depends on ipab_pkg; lowest matching index wins.
module ipab_digit_match
  import ipab_pkg::*;
(
  input  logic [SYM_W-1:0]  ch,
  input  logic [SYMS_W-1:0] syms,
  input  logic [LEN_W-1:0]  base_len,
  output digit_t            digit
);

  always_comb begin
    digit.hit   = 1'b0;
    digit.index = '0;
    for (int k = MAX_BASE - 1; k >= 0; k--) begin
      if (LEN_W'(k) < base_len && syms[k*SYM_W +: SYM_W] == ch) begin
        digit.hit   = 1'b1;
        digit.index = IDX_W'(k);
      end
    end
  end

endmodule

>>> sv/integer_parse_any_base.sv
`timescale 1ns / 1ps
// integer_parse_any_base: parses a signed integer from a character stream, one character
// per transfer, in a base whose symbols come from configuration. Sustained rate is one
// character per cycle: an input register feeds a combinational parse step (symbol lookup
// plus one accumulate of value * base_len + index) that updates the parse state and, on
// the character marked last, loads the result register. in_ready drops only while a last
// character waits in the input register and the result register holds an untaken result.
// Depends on ipab_pkg, ipab_base_check, ipab_digit_match.
module integer_parse_any_base
  import ipab_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SYM_W-1:0]        ch,
  input  logic                    last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] value,
  output logic                    base_ok
);

  logic [CFG_W-1:0] symbols_low;
  logic [CFG_W-1:0] symbols_high;
  logic [LEN_W-1:0] base_len;

  logic             s1_valid;
  logic [SYM_W-1:0] s1_ch;
  logic             s1_last;

  phase_t           phase, phase_next;
  logic             negative, negative_next;
  logic [VAL_W-1:0] accumulator, accumulator_next;

  logic [SYMS_W-1:0] syms;
  logic              cfg_ok;
  digit_t            digit;
  logic              advance;
  logic              out_free;
  logic [VAL_W-1:0]  acc_scaled;
  logic [VAL_W-1:0]  result_value;

  assign cfg_ready = 1'b1;
  assign syms      = {symbols_high, symbols_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      base_len     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        CFG_BASE_LEN:     base_len     <= cfg_data[LEN_W-1:0];
        default:          ;
      endcase
    end
  end

  ipab_base_check u_base_check (
    .syms     (syms),
    .base_len (base_len),
    .base_ok  (cfg_ok)
  );

  ipab_digit_match u_digit_match (
    .ch       (s1_ch),
    .syms     (syms),
    .base_len (base_len),
    .digit    (digit)
  );

  // a last character needs the result slot; others always move on
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch   <= ch;
      s1_last <= last;
    end
  end

  assign acc_scaled = VAL_W'(accumulator * VAL_W'(base_len));

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    if (phase_next == PH_SKIP && !is_space(s1_ch)) begin
      phase_next = PH_SIGN;
    end
    if (phase_next == PH_SIGN) begin
      if (s1_ch == CH_MINUS) begin
        negative_next = !negative;
      end else if (s1_ch != CH_PLUS) begin
        phase_next = PH_DIGITS;
      end
    end
    if (phase_next == PH_DIGITS) begin
      if (!digit.hit || s1_ch == CH_NUL) begin
        phase_next = PH_DONE;
      end else begin
        accumulator_next = acc_scaled + VAL_W'(digit.index);
      end
    end
  end

  assign result_value = !cfg_ok        ? '0 :
                        negative_next  ? VAL_W'(0) - accumulator_next : accumulator_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (advance) begin
      if (s1_last) begin
        phase       <= PH_SKIP;
        negative    <= 1'b0;
        accumulator <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      value   <= result_value;
      base_ok <= cfg_ok;
    end
  end

  a_bad_base_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !base_ok |-> value == '0)
    else $error("invalid base produced nonzero value");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> phase == PH_SKIP && !negative && accumulator == '0)
    else $error("parse state not cleared after end of string");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_ch) && $stable(s1_last))
    else $error("stalled input register overwritten");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(advance && s1_last))
    else $error("result raised without a final character");

endmodule
